/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on a rising edge and held off
// while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define AST_IMPLY(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* design/efl_pkg.sv */
// ----------------------------------------------------------------------------
// efl_pkg
// Shared types and constants of the error flag LED cycler.
// ----------------------------------------------------------------------------
`default_nettype none

package efl_pkg;

    // Width of the displayed code (fault number plus one, 0..32)
    localparam int CODE_W = 6;

    // Width of the tick counter and the display delay
    localparam int TICK_W = 32;

    // Display delay after reset
    localparam logic [TICK_W-1:0] DISPLAY_TICKS_RESET = 32'd1500;

    // Machine phases, encoded as reported on fsm_phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_DISPLAY = 2'd1,
        PH_WAIT    = 2'd2
    } phase_t;

    // One result as produced by an evaluation step
    typedef struct packed {
        phase_t              phase;
        logic [CODE_W-1:0]   code;
    } result_t;

endpackage

`default_nettype wire

/* design/error_flag_led_cycler.sv */
// ----------------------------------------------------------------------------
// error_flag_led_cycler
// Shows active fault numbers one after another on four LEDs, one request
// per evaluation step.
//
//   channel  dir  handshake         payload
//   s_*      in   tvalid / tready   error_flags, now_tick
//   m_*      out  tvalid / tready   led_pattern, shown_code, fsm_phase
//   cfg_*    in   valid / ready     display_ticks
//
// One request per cycle sustained while the m side takes every result; a
// request passes the input register, then the result register, and m_tvalid
// rises when it reaches the result register. The search and the tick compare
// settle between those two registers.
// Reset puts the machine in idle with LEDs off and display_ticks at 1500.
// A stalled m side holds its result; the input register still takes one
// more request before s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module error_flag_led_cycler #(
    parameter int FLAG_COUNT = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] error_flags, [63:32] now_tick
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [3:0] led_pattern, [9:4] shown_code,
                                        // [11:10] fsm_phase, [15:12] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data   // display_ticks
);

    logic                           in_valid_reg;
    logic [FLAG_COUNT-1:0]          flags_reg;
    logic [efl_pkg::TICK_W-1:0]     now_reg;
    logic                           out_valid_reg;
    efl_pkg::result_t               result_reg;
    efl_pkg::result_t               result_next;
    logic [efl_pkg::TICK_W-1:0]     ticks_reg;
    logic                           advance;

    // Move a request into the result register when it is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            flags_reg <= s_tdata[FLAG_COUNT-1:0];
            now_reg   <= s_tdata[63:32];
        end
    end

    // Display delay register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= efl_pkg::DISPLAY_TICKS_RESET;
        end
        else if (cfg_valid)
        begin
            ticks_reg <= cfg_data;
        end
    end

    // Evaluation step
    efl_core #(
        .FLAG_COUNT (FLAG_COUNT)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (advance),
        .flags         (flags_reg),
        .now_tick      (now_reg),
        .display_ticks (ticks_reg),
        .result_next   (result_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, result_reg.phase, result_reg.code, result_reg.code[3:0]};

    // LEDs are dark outside the display phase
    `AST_IMPLY(a_dark_outside_display, clk, rst_n,
               out_valid_reg && (result_reg.phase != efl_pkg::PH_DISPLAY),
               result_reg.code == '0)

    // A displayed code names a real fault
    `AST_IMPLY(a_code_in_range, clk, rst_n,
               out_valid_reg && (result_reg.phase == efl_pkg::PH_DISPLAY),
               (result_reg.code != '0)
               && (result_reg.code <= efl_pkg::CODE_W'(FLAG_COUNT)))

    // A committed step always shows up as a result
    `AST_NEXT(a_step_presents, clk, rst_n, advance, out_valid_reg)

endmodule

`default_nettype wire

/* design/efl_search.sv */
// ----------------------------------------------------------------------------
// efl_search
// Rotated priority encoder: finds the first set flag at or above the base
// index, wrapping round to the lowest set flag when none lies above it.
// ----------------------------------------------------------------------------
`default_nettype none

module efl_search #(
    parameter int FLAG_COUNT = 32
) (
    input  wire logic [FLAG_COUNT-1:0]                             flags,
    input  wire logic [((FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1)-1:0] base,
    output logic      [((FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1)-1:0] found_idx
);

    localparam int IDX_W = (FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1;

    logic [FLAG_COUNT-1:0] upper_mask;
    logic [FLAG_COUNT-1:0] upper_flags;
    logic [FLAG_COUNT-1:0] pick_flags;
    logic [FLAG_COUNT-1:0] lowest_onehot;

    // Keep only flags at or above the base index
    always_comb
    begin
        for (int i = 0; i < FLAG_COUNT; i++)
        begin
            upper_mask[i] = (IDX_W'(i) >= base);
        end
    end

    assign upper_flags = flags & upper_mask;

    // Fall back to the whole word when nothing lies above the base
    assign pick_flags = (|upper_flags) ? upper_flags : flags;

    // Isolate the lowest set bit
    assign lowest_onehot = pick_flags & (~pick_flags + FLAG_COUNT'(1));

    // Encode the one-hot position
    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < FLAG_COUNT; i++)
        begin
            if (lowest_onehot[i])
            begin
                found_idx = found_idx | IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

/* design/efl_core.sv */
// ----------------------------------------------------------------------------
// efl_core
// Phase machine, search index, timer start and lit code of the cycler.
// Computes one evaluation step and commits it when the step is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module efl_core #(
    parameter int FLAG_COUNT = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step_en,
    input  wire logic [FLAG_COUNT-1:0]         flags,
    input  wire logic [efl_pkg::TICK_W-1:0]    now_tick,
    input  wire logic [efl_pkg::TICK_W-1:0]    display_ticks,
    output efl_pkg::result_t                   result_next
);

    localparam int IDX_W = (FLAG_COUNT > 1) ? $clog2(FLAG_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FLAG_COUNT - 1);

    efl_pkg::phase_t                phase_reg;
    efl_pkg::phase_t                phase_next;
    logic [IDX_W-1:0]               index_reg;
    logic [IDX_W-1:0]               index_next;
    logic [efl_pkg::TICK_W-1:0]     start_reg;
    logic [efl_pkg::TICK_W-1:0]     start_next;
    logic [efl_pkg::CODE_W-1:0]     led_reg;
    logic [efl_pkg::CODE_W-1:0]     led_next;

    logic [IDX_W-1:0]               found_idx;
    logic [efl_pkg::TICK_W-1:0]     elapsed;
    logic                           timed_out;
    logic                           any_flag;

    // Find the next active fault from the current index
    efl_search #(
        .FLAG_COUNT (FLAG_COUNT)
    ) u_search (
        .flags     (flags),
        .base      (index_reg),
        .found_idx (found_idx)
    );

    // Wrapping tick difference against the delay
    assign elapsed   = now_tick - start_reg;
    assign timed_out = (elapsed >= display_ticks);
    assign any_flag  = |flags;

    // Next state of the phase machine
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        start_next = start_reg;
        led_next   = led_reg;
        unique case (phase_reg)
            efl_pkg::PH_DISPLAY:
            begin
                if (timed_out)
                begin
                    led_next   = '0;
                    start_next = now_tick;
                    index_next = (index_reg == IDX_LAST) ? '0 : index_reg + IDX_W'(1);
                    phase_next = efl_pkg::PH_WAIT;
                end
                else if (!any_flag)
                begin
                    led_next   = '0;
                    index_next = '0;
                    phase_next = efl_pkg::PH_IDLE;
                end
            end
            efl_pkg::PH_WAIT:
            begin
                if (any_flag)
                begin
                    led_next   = efl_pkg::CODE_W'(found_idx) + efl_pkg::CODE_W'(1);
                    index_next = found_idx;
                    start_next = now_tick;
                    phase_next = efl_pkg::PH_DISPLAY;
                end
                else
                begin
                    led_next   = '0;
                    index_next = '0;
                    phase_next = efl_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = efl_pkg::PH_IDLE;
                if (any_flag)
                begin
                    led_next   = efl_pkg::CODE_W'(found_idx) + efl_pkg::CODE_W'(1);
                    index_next = found_idx;
                    start_next = now_tick;
                    phase_next = efl_pkg::PH_DISPLAY;
                end
            end
        endcase
    end

    // Commit the step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= efl_pkg::PH_IDLE;
            index_reg <= '0;
            start_reg <= '0;
            led_reg   <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            start_reg <= start_next;
            led_reg   <= led_next;
        end
    end

    assign result_next.phase = phase_next;
    assign result_next.code  = led_next;

endmodule

`default_nettype wire

/* test/error_flag_led_cycler_test.sv */
// ----------------------------------------------------------------------------
// error_flag_led_cycler_test
// Self-checking bench for the fault LED cycler. A queue of (flags, tick)
// requests feeds a clocked stream driver; every accepted request is run
// through a local model of the idle/display/wait machine and the predicted
// LED view is matched field by field against the result stream. Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// display delay is rewritten between phases, zero and all-ones included.
// ----------------------------------------------------------------------------
module error_flag_led_cycler_test;

    localparam int          FLAG_COUNT   = 32;
    localparam logic [31:0] FLAG_MASK    = 32'hFFFF_FFFF >> (32 - FLAG_COUNT);
    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          HOLD_CYCLES  = 300;

    // One request toward the block and one predicted LED view
    typedef struct {
        logic [31:0] flags;
        logic [31:0] tick;
    } fault_sample_t;

    typedef struct {
        logic [3:0]                 led_pattern;
        logic [efl_pkg::CODE_W-1:0] shown_code;
        efl_pkg::phase_t            fsm_phase;
    } led_view_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] error_flags, [63:32] now_tick
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [3:0] led_pattern, [9:4] shown_code,
                                   // [11:10] fsm_phase, [15:12] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;   // display_ticks

    // Pending requests and predicted LED views
    fault_sample_t pending_samples[$];
    led_view_t     led_expect[$];

    // Local copy of the cycler state and its delay register
    efl_pkg::phase_t            cyc_phase  = efl_pkg::PH_IDLE;
    logic [4:0]                 scan_index = '0;
    logic [31:0]                lit_since  = '0;
    logic [efl_pkg::CODE_W-1:0] lit_code   = '0;
    logic [31:0]                hold_ticks = efl_pkg::DISPLAY_TICKS_RESET;

    int  sent_count   = 0;
    int  result_count = 0;
    int  fail_count   = 0;
    int  delay_count  = 0;
    int  stall_cycles = 0;
    int  tx_gap       = 0;
    int  rx_wait      = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;
    logic hold_off    = 1'b0;

    logic [31:0] tick_now   = '0;
    logic [31:0] live_flags = '0;

    error_flag_led_cycler #(
        .FLAG_COUNT (FLAG_COUNT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock: 12 units period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Pick the next idle gap: mostly none or short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Round-robin search from the index, light the hit, restart the timer
    function automatic void light_next(input logic [31:0] flags, input logic [31:0] now);
        int  base;
        int  pos;
        bit  found;
        base  = int'(scan_index) % FLAG_COUNT;
        found = 1'b0;
        for (int k = 0; k < FLAG_COUNT; k++)
        begin
            pos = (base + k) % FLAG_COUNT;
            if (!found && flags[pos])
            begin
                found      = 1'b1;
                scan_index = pos[4:0];
                lit_code   = efl_pkg::CODE_W'(pos + 1);
            end
        end
        lit_since = now;
        cyc_phase = efl_pkg::PH_DISPLAY;
    endfunction

    // Advance the machine by one request and return the LED view after it
    function automatic led_view_t step_cycler(input logic [31:0] raw_flags,
                                              input logic [31:0] now);
        logic [31:0] flags;
        logic [31:0] elapsed;
        led_view_t   view;
        int          nxt;
        flags   = raw_flags & FLAG_MASK;
        elapsed = now - lit_since;
        case (cyc_phase)
            efl_pkg::PH_DISPLAY:
            begin
                if (elapsed >= hold_ticks)
                begin
                    lit_code   = '0;
                    lit_since  = now;
                    nxt        = (int'(scan_index) % FLAG_COUNT + 1) % FLAG_COUNT;
                    scan_index = nxt[4:0];
                    cyc_phase  = efl_pkg::PH_WAIT;
                end
                else if (flags == '0)
                begin
                    lit_code   = '0;
                    scan_index = '0;
                    cyc_phase  = efl_pkg::PH_IDLE;
                end
            end
            efl_pkg::PH_WAIT:
            begin
                if (flags != '0)
                    light_next(flags, now);
                else
                begin
                    lit_code   = '0;
                    scan_index = '0;
                    cyc_phase  = efl_pkg::PH_IDLE;
                end
            end
            default:
            begin
                cyc_phase = efl_pkg::PH_IDLE;
                if (flags != '0)
                    light_next(flags, now);
            end
        endcase
        view.led_pattern = lit_code[3:0];
        view.shown_code  = lit_code;
        view.fsm_phase   = cyc_phase;
        return view;
    endfunction

    // Driver: offer queued requests, predict each one as it is taken
    always @(posedge clk)
    begin : drive_requests
        fault_sample_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                led_expect.push_back(step_cycler(s_tdata[31:0], s_tdata[63:32]));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    nxt = pending_samples.pop_front();
                    s_tdata  <= {nxt.tick, nxt.flags};
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 99) == 0)
                        tx_calm = !tx_calm;
                    tx_gap = pick_gap(tx_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: match each result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        led_view_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (led_expect.size() == 0)
                begin
                    $error("result 0x%h arrived with no request outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = led_expect.pop_front();
                    if (m_tdata[3:0] !== want.led_pattern)
                    begin
                        $error("led_pattern: expected %0d, got %0d",
                               want.led_pattern, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tdata[9:4] !== want.shown_code)
                    begin
                        $error("shown_code: expected %0d, got %0d",
                               want.shown_code, m_tdata[9:4]);
                        fail_count++;
                    end
                    if (m_tdata[11:10] !== want.fsm_phase)
                    begin
                        $error("fsm_phase: expected %0d, got %0d",
                               want.fsm_phase, m_tdata[11:10]);
                        fail_count++;
                    end
                end
            end
            // Stall the result side at random, or hold it off entirely
            if (rx_wait > 0)
            begin
                rx_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !hold_off;
                if ($urandom_range(0, 99) == 0)
                    rx_calm = !rx_calm;
                rx_wait = pick_gap(rx_calm);
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering
    initial
    begin : backpressure
        while (sent_count < 700)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic queue_sample(input logic [31:0] flags, input logic [31:0] tick);
        fault_sample_t smp;
        smp.flags = flags;
        smp.tick  = tick;
        pending_samples.push_back(smp);
        tick_now = tick;
    endtask

    // Wait until every request has been answered
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || led_expect.size() != 0)
            @(posedge clk);
    endtask

    // Rewrite the display delay once the block has gone quiet
    task automatic write_display_ticks(input logic [31:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        hold_ticks  = value;
        delay_count++;
    endtask

    // Random requests: persistent fault sets with ticks clustered near the delay
    task automatic queue_random(input int count);
        int          r;
        logic [31:0] near;
        logic [31:0] step;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < 20)
            begin
                r = $urandom_range(0, 99);
                if (r < 25)
                    live_flags = '0;
                else if (r < 45)
                    live_flags = 32'd1 << $urandom_range(0, 31);
                else if (r < 58)
                    live_flags = 32'hFFFF_FFFF;
                else if (r < 85)
                    live_flags = $urandom & $urandom & $urandom;
                else
                    live_flags = $urandom;
            end
            near = (hold_ticks > 32'd16) ? 32'd16 : hold_ticks;
            r    = $urandom_range(0, 99);
            if (r < 65)
                step = $urandom_range(0, int'(near) + 2);
            else if (r < 85)
                step = hold_ticks - 32'd1 + $urandom_range(0, 2);
            else if (r < 95)
                step = $urandom;
            else
                step = '0;
            queue_sample(live_flags, tick_now + step);
        end
    endtask

    initial
    begin : run_test
        logic [31:0] delays[9];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset delay: single top fault, wrapped tick difference, exact timeout
        queue_sample(32'h0000_0000, 32'h0000_0000);
        queue_sample(32'h8000_0000, 32'h0000_000A);
        queue_sample(32'h8000_0000, 32'h0000_0064);
        queue_sample(32'h0000_0000, 32'h0000_00C8);
        queue_sample(32'h8000_0001, 32'hFFFF_FF00);
        queue_sample(32'h8000_0001, 32'h0000_0100);
        queue_sample(32'h8000_0001, 32'h0000_05DC);
        queue_sample(32'h8000_0001, 32'h0000_05DD);
        queue_sample(32'h8000_0001, 32'h0000_0BB9);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0BBA);
        queue_sample(32'hFFFF_FFFF, 32'h0000_1194);
        queue_sample(32'hFFFF_FFFF, 32'h0000_1196);
        queue_sample(32'h0000_0000, 32'h0000_1200);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_sample(32'h0000_FFFF, 32'h7FFF_FFFF);

        // Zero delay: display times out on the very next step
        write_display_ticks(32'd0);
        @(negedge clk);
        queue_sample(32'h0000_0004, 32'd5);
        queue_sample(32'h0000_0004, 32'd5);
        queue_sample(32'h0000_0004, 32'd5);
        queue_sample(32'h0000_0000, 32'd6);
        queue_sample(32'hAAAA_AAAA, 32'd7);
        queue_sample(32'hAAAA_AAAA, 32'd7);
        queue_sample(32'hAAAA_AAAA, 32'd7);
        queue_sample(32'hAAAA_AAAA, 32'd7);

        // All-ones delay: only a full wrap of the tick difference times out
        write_display_ticks(32'hFFFF_FFFF);
        @(negedge clk);
        queue_sample(32'h0000_0001, 32'h0000_0001);
        queue_sample(32'h0000_0001, 32'h0000_0000);
        queue_sample(32'h0000_0001, 32'h0000_0000);
        queue_sample(32'h0000_0001, 32'hFFFF_FFFE);
        queue_sample(32'h0000_0000, 32'h0000_0003);

        // Random phases over a spread of delays
        delays = '{32'd3, 32'd0, 32'd1, 32'd17, efl_pkg::DISPLAY_TICKS_RESET, $urandom,
                   32'hFFFF_FFFF, 32'd8, 32'd2};
        foreach (delays[d])
        begin
            write_display_ticks(delays[d]);
            @(negedge clk);
            queue_random(210);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (led_expect.size() != 0)
        begin
            $error("%0d predicted results never arrived", led_expect.size());
            fail_count++;
        end
        $display("checked %0d requests and %0d results across %0d delay writes",
                 sent_count, result_count, delay_count);
        $display("delays covered zero, all-ones, reset value and small timeouts");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
